// ===== design/msrc_pkg.sv =====
// ----------------------------------------------------------------------------
// msrc_pkg
// Shared types, constants and the CRC-16 byte update for the sensor reply
// checker.
// ----------------------------------------------------------------------------
`default_nettype none

package msrc_pkg;

	localparam int unsigned FRAME_BYTES_DEF = 13;

	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam logic [7:0]  ADDR_RESET = 8'hFE;
	localparam logic [7:0]  FUNC_RESET = 8'h04;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ADDRESS  = 2'd0,
		CFG_FUNCTION = 2'd1
	} cfg_index_t;

	typedef enum logic [1:0] {
		RC_OK        = 2'd0,
		RC_BAD_ID    = 2'd1,
		RC_BAD_CRC   = 2'd2,
		RC_BAD_COUNT = 2'd3
	} result_code_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
		input logic [7:0] data);
		logic [15:0] crc;
		crc = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (crc[0]) begin
				crc = (crc >> 1) ^ CRC_POLY;
			end else begin
				crc = crc >> 1;
			end
		end
		return crc;
	endfunction

endpackage

`default_nettype wire

// ===== design/modbus_sensor_reply_checker.sv =====
// ----------------------------------------------------------------------------
// modbus_sensor_reply_checker
// Checks fixed-length sensor replies byte by byte: address and function,
// CRC-16, byte count, and extracts the status and CO2 words.
// ----------------------------------------------------------------------------
// Takes one byte per cycle on the item channel; the last byte of a frame,
// once accepted, passes the input register and then the result register, where
// its result appears. The byte rate is set by the combinational CRC-16 byte
// update between the two registers. Only the last byte of a frame produces a
// result; the item channel stalls only while a finished result waits and the
// byte in the input register is the last of the next frame. Configuration
// writes must be made while no frame is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_sensor_reply_checker #(
	parameter int unsigned FRAME_BYTES = msrc_pkg::FRAME_BYTES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,

	input  wire logic                             cfg_we,
	input  wire logic [msrc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [msrc_pkg::CFG_DATA_W-1:0]  cfg_wdata,

	input  wire logic                             item_valid,
	output logic                                  item_ready,
	input  wire logic [7:0]                       rx_byte,
	input  wire logic                             frame_start,

	output logic                                  result_valid,
	input  wire logic                             result_ready,
	output logic [1:0]                            result_code,
	output logic [15:0]                           co2_ppm,
	output logic [15:0]                           sensor_status,
	output logic [15:0]                           computed_crc
);
	import msrc_pkg::*;

	localparam int unsigned IDX_W = $clog2(FRAME_BYTES);
	localparam logic [IDX_W-1:0] POS_ADDR   = IDX_W'(0);
	localparam logic [IDX_W-1:0] POS_FUNC   = IDX_W'(1);
	localparam logic [IDX_W-1:0] POS_COUNT  = IDX_W'(2);
	localparam logic [IDX_W-1:0] POS_STAT_H = IDX_W'(3);
	localparam logic [IDX_W-1:0] POS_STAT_L = IDX_W'(4);
	localparam logic [IDX_W-1:0] POS_CRC_LO = IDX_W'(FRAME_BYTES - 2);
	localparam logic [IDX_W-1:0] POS_LAST   = IDX_W'(FRAME_BYTES - 1);
	localparam logic [8:0]       FRAME_LEN9 = 9'(FRAME_BYTES);

	logic [7:0]       exp_addr_q;
	logic [7:0]       exp_func_q;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             start_s1;

	logic [IDX_W-1:0] byte_index_q;
	logic [15:0]      crc_q;
	logic [7:0]       addr_q;
	logic [7:0]       func_q;
	logic [7:0]       count_q;
	logic [7:0]       stat_hi_q;
	logic [7:0]       stat_lo_q;
	logic [7:0]       crc_lo_q;
	logic [7:0]       co2_hi_q;
	logic [7:0]       co2_lo_q;

	logic             out_valid_q;
	result_code_t     code_q;
	logic [15:0]      co2_q;
	logic [15:0]      status_q;
	logic [15:0]      crc_out_q;

	logic [IDX_W-1:0] pos;
	logic [15:0]      crc_in;
	logic [15:0]      crc_next;
	logic             is_last;
	logic             adv;
	logic [8:0]       pos9;
	logic [8:0]       count_p1;
	logic [8:0]       count_p2;
	logic [7:0]       co2_lo_fin;
	logic [15:0]      rx_crc;
	result_code_t     code_fin;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_addr_q <= ADDR_RESET;
			exp_func_q <= FUNC_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ADDRESS:  exp_addr_q <= cfg_wdata;
				CFG_FUNCTION: exp_func_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// byte processing between input register and result register
	always_comb begin
		pos      = (start_s1 || (byte_index_q > POS_LAST)) ? POS_ADDR : byte_index_q;
		crc_in   = start_s1 ? CRC_INIT : crc_q;
		crc_next = (pos < POS_CRC_LO) ? crc16_byte(crc_in, byte_s1) : crc_in;
		is_last  = (pos == POS_LAST);
		adv      = valid_s1 && (!is_last || !out_valid_q || result_ready);
		pos9     = 9'(pos);
		count_p1 = {1'b0, count_q} + 9'd1;
		count_p2 = {1'b0, count_q} + 9'd2;
		co2_lo_fin = (pos9 == count_p2) ? byte_s1 : co2_lo_q;
		rx_crc   = {byte_s1, crc_lo_q};
		priority if (addr_q != exp_addr_q || func_q != exp_func_q) begin
			code_fin = RC_BAD_ID;
		end else if (rx_crc != crc_in) begin
			code_fin = RC_BAD_CRC;
		end else if (count_p2 >= FRAME_LEN9) begin
			code_fin = RC_BAD_COUNT;
		end else begin
			code_fin = RC_OK;
		end
	end

	assign item_ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			byte_s1  <= rx_byte;
			start_s1 <= frame_start;
		end
	end

	// frame position and CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			crc_q        <= CRC_INIT;
		end else if (adv) begin
			if (is_last) begin
				byte_index_q <= '0;
				crc_q        <= CRC_INIT;
			end else begin
				byte_index_q <= pos + IDX_W'(1);
				crc_q        <= crc_next;
			end
		end
	end

	// captured frame fields
	always_ff @(posedge clk) begin
		if (adv) begin
			if (pos == POS_ADDR)   addr_q    <= byte_s1;
			if (pos == POS_FUNC)   func_q    <= byte_s1;
			if (pos == POS_STAT_H) stat_hi_q <= byte_s1;
			if (pos == POS_STAT_L) stat_lo_q <= byte_s1;
			if (pos == POS_CRC_LO) crc_lo_q  <= byte_s1;
			if (pos == POS_COUNT) begin
				count_q <= byte_s1;
				if (byte_s1 == 8'd0) begin
					co2_hi_q <= func_q;
					co2_lo_q <= byte_s1;
				end else if (byte_s1 == 8'd1) begin
					co2_hi_q <= byte_s1;
				end
			end else if (pos > POS_COUNT) begin
				if (pos9 == count_p1) co2_hi_q <= byte_s1;
				if (pos9 == count_p2) co2_lo_q <= byte_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && is_last) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && is_last) begin
			code_q    <= code_fin;
			crc_out_q <= crc_in;
			if (code_fin == RC_OK) begin
				co2_q    <= {co2_hi_q, co2_lo_fin};
				status_q <= {stat_hi_q, stat_lo_q};
			end else begin
				co2_q    <= '0;
				status_q <= '0;
			end
		end
	end

	assign result_valid  = out_valid_q;
	assign result_code   = code_q;
	assign co2_ppm       = co2_q;
	assign sensor_status = status_q;
	assign computed_crc  = crc_out_q;

`ifndef SYNTHESIS
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_index_q <= POS_LAST)
		else $error("frame position out of range");

	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> (valid_s1 && out_valid_q && !result_ready))
		else $error("input stalled without a blocked result");

	a_bad_result_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && code_q != RC_OK) |-> (co2_q == 16'd0 && status_q == 16'd0))
		else $error("failed frame carries data words");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && is_last) |=> (byte_index_q == POS_ADDR && crc_q == CRC_INIT && out_valid_q))
		else $error("frame end did not restart state");
`endif

endmodule

`default_nettype wire
